[rtl/mm_pkg.sv]
// Shared widths, opcodes and register indexes for the matrix multiply block.
package mm_pkg;

    // Fixed field widths
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int VALUE_W = 16;
    localparam int DOT_W   = 35;
    localparam int OP_W    = 2;

    // APB port widths
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

endpackage

[rtl/matrix_multiply.sv]
// Top level of the integer matrix multiply block: stores, sequencer, MAC pipeline, APB.
//
// Load requests (opcode 0 writes A, opcode 1 writes B at row*MAX_DIM+col) are taken one
// per cycle and produce no result; loads outside MAX_DIM and opcode 3 are dropped. A
// compute request streams rows_a*cols_b results in row-major order, last set on the
// final one; dimensions of zero count as 1 and values above MAX_DIM as MAX_DIM. Each
// store is one RAM with a single read port, so a product element takes one read of each
// store per inner_dim term, then passes through read, multiply and hand-off: a compute
// request occupies the block until its final result enters the output register, and it
// stalls while m_ready holds a result back. New requests are taken only between
// compute runs, including while the final result still waits in the output register.
// Both stores read as zero after reset through per-entry valid flops, so no clearing
// pass is needed. Configuration goes through APB at byte addresses 0, 4 and 8.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_opcode,
    input  logic [IDX_W-1:0]          s_row,
    input  logic [IDX_W-1:0]          s_col,
    input  logic signed [VALUE_W-1:0] s_value,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_out_row,
    output logic [IDX_W-1:0]          m_out_col,
    output logic signed [DOT_W-1:0]   m_dot,
    output logic                      m_last
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int AFULL_W = 2 * IDX_W + 1;
    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] ONE_D = DIM_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    // Dimension clamp: zero counts as one, large values saturate
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return ONE_D;
        end else if (d > MAX_D) begin
            return MAX_D;
        end
        return d;
    endfunction

    // Store address row*MAX_DIM+col
    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        logic [AFULL_W-1:0] t;
        t = AFULL_W'(r) * AFULL_W'(MAX_DIM) + AFULL_W'(c);
        return t[ADDR_W-1:0];
    endfunction

    // Registers
    state_t                   state_reg, state_next;
    logic [DIM_W-1:0]         rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DEPTH-1:0]         valid_a_reg, valid_b_reg;
    logic                     s1_vld_reg, s1_lastk_reg, va_reg, vb_reg;
    logic                     p_vld_reg, p_lastk_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]  acc_reg, hold_reg, hold_next;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic signed [DOT_W-1:0]  m_dot_reg, m_dot_next;
    logic                     m_last_reg, m_last_next;

    // Combinational signals
    logic [DIM_W-1:0]         m_dim, n_dim, p_dim;
    logic                     cfg_wr, in_accept, in_range, wr_a, wr_b;
    logic [ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    logic [ELEM_BITS-1:0]     wr_elem, rd_data_a, rd_data_b;
    logic                     rd_en, i_last, j_last, k_last, done, out_free, m_load;
    logic signed [ELEM_BITS-1:0] a_op, b_op;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [DOT_W-1:0]  prod_ext, sum;

    assign m_dim = clamp_dim(rows_a_reg);
    assign n_dim = clamp_dim(inner_dim_reg);
    assign p_dim = clamp_dim(cols_b_reg);

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ROWS_A:    prdata = APB_DW'(rows_a_reg);
            REG_INNER_DIM: prdata = APB_DW'(inner_dim_reg);
            REG_COLS_B:    prdata = APB_DW'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    // Load path: element wrapped or sign-extended to ELEM_BITS
    generate
        if (ELEM_BITS <= VALUE_W) begin : g_elem_trunc
            assign wr_elem = s_value[ELEM_BITS-1:0];
        end else begin : g_elem_sext
            assign wr_elem = {{(ELEM_BITS-VALUE_W){s_value[VALUE_W-1]}}, s_value};
        end
    endgenerate

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign in_range  = (DIM_W'(s_row) < MAX_D) && (DIM_W'(s_col) < MAX_D);
    assign wr_a      = in_accept && in_range && (opcode_t'(s_opcode) == OP_LOAD_A);
    assign wr_b      = in_accept && in_range && (opcode_t'(s_opcode) == OP_LOAD_B);
    assign wr_addr   = elem_addr(s_row, s_col);

    // Read side: A[i][k] and B[k][j]
    assign rd_en     = (state_reg == ST_ISSUE);
    assign rd_addr_a = elem_addr(i_reg, k_reg);
    assign rd_addr_b = elem_addr(k_reg, j_reg);

    mm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_left_store (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    mm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_right_store (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Multiply stage: unwritten entries read as zero
    assign a_op      = va_reg ? signed'(rd_data_a) : '0;
    assign b_op      = vb_reg ? signed'(rd_data_b) : '0;
    assign prod_full = a_op * b_op;

    // Product fitted to the dot width (wraps modulo 2^DOT_W)
    generate
        if (PROD_W >= DOT_W) begin : g_prod_trunc
            assign prod_ext = prod_reg[DOT_W-1:0];
        end else begin : g_prod_sext
            assign prod_ext = {{(DOT_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    endgenerate

    assign sum  = acc_reg + prod_ext;
    assign done = p_vld_reg && p_lastk_reg;

    assign i_last   = (DIM_W'(i_reg) == m_dim - ONE_D);
    assign j_last   = (DIM_W'(j_reg) == p_dim - ONE_D);
    assign k_last   = (DIM_W'(k_reg) == n_dim - ONE_D);
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        hold_next  = hold_reg;
        m_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (opcode_t'(s_opcode) == OP_COMPUTE)) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    hold_next  = sum;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_load = 1'b1;
                    if (i_last && j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end else begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_dot_next   = m_dot_reg;
        m_last_next  = m_last_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
            m_row_next   = i_reg;
            m_col_next   = j_reg;
            m_dot_next   = hold_reg;
            m_last_next  = i_last && j_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State, pipeline and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_a_reg    <= DIM_W'(2);
            inner_dim_reg <= DIM_W'(2);
            cols_b_reg    <= DIM_W'(2);
            valid_a_reg   <= '0;
            valid_b_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            p_vld_reg     <= 1'b0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s1_vld_reg  <= rd_en;
            p_vld_reg   <= s1_vld_reg;
            m_valid_reg <= m_valid_next;
            if (p_vld_reg) begin
                acc_reg <= p_lastk_reg ? '0 : sum;
            end
            if (wr_a) begin
                valid_a_reg[wr_addr] <= 1'b1;
            end
            if (wr_b) begin
                valid_b_reg[wr_addr] <= 1'b1;
            end
            if (cfg_wr) begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_ROWS_A:    rows_a_reg    <= pwdata[DIM_W-1:0];
                    REG_INNER_DIM: inner_dim_reg <= pwdata[DIM_W-1:0];
                    REG_COLS_B:    cols_b_reg    <= pwdata[DIM_W-1:0];
                    default:       ;
                endcase
            end
        end
        // payload, no reset
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        hold_reg     <= hold_next;
        s1_lastk_reg <= k_last;
        p_lastk_reg  <= s1_lastk_reg;
        prod_reg     <= prod_full;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_dot_reg    <= m_dot_next;
        m_last_reg   <= m_last_next;
        if (rd_en) begin
            va_reg <= valid_a_reg[rd_addr_a];
            vb_reg <= valid_b_reg[rd_addr_b];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;
    assign m_dot     = m_dot_reg;
    assign m_last    = m_last_reg;

`ifndef NO_ASSERTIONS
    // a finished dot product only lands while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == ST_DRAIN))
        else $error("dot product completed outside drain");

    // the MAC pipeline is empty whenever new requests are taken
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!s1_vld_reg && !p_vld_reg))
        else $error("MAC pipeline busy while idle");

    // a compute request starts the read sweep in the next cycle
    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_opcode == OP_COMPUTE)) |=> (state_reg == ST_ISSUE))
        else $error("compute request did not start");

    // last marks the bottom-right product element
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |->
            ((DIM_W'(m_row_reg) == m_dim - ONE_D) && (DIM_W'(m_col_reg) == p_dim - ONE_D)))
        else $error("last flag on wrong element");
`endif

endmodule

[rtl/mm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[dv/testbench.sv]
// Self-checking testbench for matrix_multiply: directed and random requests vs. a predictor.
module testbench;
    import mm_pkg::*;

    localparam int               DIM_MAX      = 8;
    localparam logic [OP_W-1:0]  OP_RESERVED  = 2'd3;
    localparam int               CYCLE_LIMIT  = 1000000;
    localparam int               RANDOM_REQS  = 400;
    localparam int               NUM_PHASES   = 8;
    localparam int               GAP_PERCENT  = 11;
    localparam int               SETTLE_CYCLES = 8;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } mm_req_t;

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } product_t;

    // Directed row: request plus, where obvious, a dot value shared by every product element
    typedef struct {
        mm_req_t req;
        bit      pinned;
        longint  dot;
    } directed_t;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_AW-1:0]         paddr   = '0;
    logic [APB_DW-1:0]         pwdata  = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_opcode = '0;
    logic [IDX_W-1:0]          s_row    = '0;
    logic [IDX_W-1:0]          s_col    = '0;
    logic signed [VALUE_W-1:0] s_value  = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic [IDX_W-1:0]          m_out_row;
    logic [IDX_W-1:0]          m_out_col;
    logic signed [DOT_W-1:0]   m_dot;
    logic                      m_last;

    // Predictor state: element stores, dimension registers, pending products
    logic signed [VALUE_W-1:0] a_elems [DIM_MAX*DIM_MAX];
    logic signed [VALUE_W-1:0] b_elems [DIM_MAX*DIM_MAX];
    logic [DIM_W-1:0]          rows_cfg  = 4'd2;
    logic [DIM_W-1:0]          inner_cfg = 4'd2;
    logic [DIM_W-1:0]          cols_cfg  = 4'd2;
    product_t                  product_q [$];
    int                        mismatches = 0;
    int                        cycles     = 0;
    bit                        no_gaps    = 1'b0;

    directed_t directed_rows [21] = '{
        '{'{OP_COMPUTE,  3'd0, 3'd0, 16'h0000}, 1'b1, 64'sd0},           // cleared stores
        '{'{OP_LOAD_A,   3'd0, 3'd0, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_A,   3'd0, 3'd1, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_A,   3'd1, 3'd0, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_A,   3'd1, 3'd1, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd0, 3'd0, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd0, 3'd1, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd1, 3'd0, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd1, 3'd1, 16'h8000}, 1'b0, 64'sd0},
        '{'{OP_COMPUTE,  3'd0, 3'd0, 16'h0000}, 1'b1, 64'sd2147483648},  // 2 * (-2^15)^2
        '{'{OP_LOAD_B,   3'd0, 3'd0, 16'h7fff}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd0, 3'd1, 16'h7fff}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd1, 3'd0, 16'h7fff}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd1, 3'd1, 16'h7fff}, 1'b0, 64'sd0},
        '{'{OP_COMPUTE,  3'd7, 3'd7, 16'hffff}, 1'b1, -64'sd2147418112}, // 2 * -2^15 * (2^15-1)
        '{'{OP_LOAD_A,   3'd7, 3'd7, 16'h7fff}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd7, 3'd7, 16'hffff}, 1'b0, 64'sd0},
        '{'{OP_RESERVED, 3'd0, 3'd0, 16'h1234}, 1'b0, 64'sd0},           // must be dropped
        '{'{OP_LOAD_A,   3'd0, 3'd1, 16'h0001}, 1'b0, 64'sd0},
        '{'{OP_LOAD_B,   3'd1, 3'd0, 16'h5a5a}, 1'b0, 64'sd0},
        '{'{OP_COMPUTE,  3'd5, 3'd2, 16'ha5a5}, 1'b0, 64'sd0}
    };

    matrix_multiply u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_dot     (m_dot),
        .m_last    (m_last)
    );

    always #2 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
    end

    // Zero and out-of-range dimensions are clamped into 1..MAX_DIM
    function automatic int clamp_dim(logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_MAX)
            return DIM_MAX;
        return int'(d);
    endfunction

    function automatic void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // Update the element stores, or queue every product element of a compute request
    function automatic void matmul_apply(mm_req_t r, bit pinned, longint pinned_dot);
        int       m;
        int       n;
        int       p;
        longint   acc;
        product_t pr;
        m = clamp_dim(rows_cfg);
        n = clamp_dim(inner_cfg);
        p = clamp_dim(cols_cfg);
        case (r.op)
            OP_LOAD_A: a_elems[r.row*DIM_MAX + r.col] = r.value;
            OP_LOAD_B: b_elems[r.row*DIM_MAX + r.col] = r.value;
            OP_COMPUTE: begin
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < p; j++) begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(a_elems[i*DIM_MAX + k]) *
                                   longint'(b_elems[k*DIM_MAX + j]);
                        pr.row  = IDX_W'(i);
                        pr.col  = IDX_W'(j);
                        pr.dot  = DOT_W'(pinned ? pinned_dot : acc);
                        pr.last = (i == m - 1) && (j == p - 1);
                        product_q = {product_q, pr};
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Present one request, hold it until taken, then update the predictor
    task automatic send_req(mm_req_t r, bit pinned, longint pinned_dot);
        bit took;
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= r.op;
        s_row    <= r.row;
        s_col    <= r.col;
        s_value  <= r.value;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        matmul_apply(r, pinned, pinned_dot);
    endtask

    // Stop requests and wait until all products are back and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB writes of all three dimension registers, back to back
    task automatic write_dims(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n, logic [DIM_W-1:0] p);
        reg_idx_t         regs [3];
        logic [DIM_W-1:0] vals [3];
        regs = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
        vals = '{m, n, p};
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= APB_DW'(vals[i]);
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        rows_cfg  = m;
        inner_cfg = n;
        cols_cfg  = p;
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly inside the active dimension, sometimes anywhere in the store
    function automatic logic [IDX_W-1:0] rand_idx(int lim);
        if ($urandom_range(0, 3) != 0)
            return IDX_W'($urandom_range(0, lim - 1));
        return IDX_W'($urandom_range(0, DIM_MAX - 1));
    endfunction

    // Random loads, row/column fills, reserved opcodes and computes under the current dimensions
    task automatic run_random(int count);
        mm_req_t                   r;
        int                        sent;
        int                        pick;
        int                        m;
        int                        n;
        int                        p;
        int                        fi;
        int                        fj;
        logic signed [VALUE_W-1:0] va;
        logic signed [VALUE_W-1:0] vb;
        sent = 0;
        m = clamp_dim(rows_cfg);
        n = clamp_dim(inner_cfg);
        p = clamp_dim(cols_cfg);
        while (sent < count) begin
            pick    = $urandom_range(0, 99);
            r.row   = IDX_W'($urandom);
            r.col   = IDX_W'($urandom);
            r.value = VALUE_W'($urandom);
            if (pick < 10) begin
                r.op = OP_COMPUTE;
                send_req(r, 1'b0, 0);
                sent++;
            end else if (pick < 14) begin
                // dropped by the block, not counted
                r.op = OP_RESERVED;
                send_req(r, 1'b0, 0);
            end else if (pick < 22) begin
                // fill one row of A and one column of B
                fi = $urandom_range(0, m - 1);
                fj = $urandom_range(0, p - 1);
                va = rand_value();
                vb = rand_value();
                for (int k = 0; k < n; k++) begin
                    send_req('{OP_LOAD_A, IDX_W'(fi), IDX_W'(k), va}, 1'b0, 0);
                    send_req('{OP_LOAD_B, IDX_W'(k), IDX_W'(fj), vb}, 1'b0, 0);
                    sent += 2;
                end
            end else begin
                r.op    = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
                r.row   = rand_idx(r.op == OP_LOAD_A ? m : n);
                r.col   = rand_idx(r.op == OP_LOAD_A ? n : p);
                r.value = rand_value();
                send_req(r, 1'b0, 0);
                sent++;
            end
        end
        r.op = OP_COMPUTE;
        send_req(r, 1'b0, 0);
    endtask

    // Product checker: sampled mid-cycle, the request completes at the next rising edge
    always @(negedge aclk) begin
        product_t exp_p;
        if (aresetn && m_valid && m_ready) begin
            if (product_q.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected product: row %0d col %0d dot %0d last %0b",
                    m_out_row, m_out_col, m_dot, m_last));
            end else begin
                exp_p = product_q.pop_front();
                if (m_out_row !== exp_p.row || m_out_col !== exp_p.col ||
                    m_dot !== exp_p.dot || m_last !== exp_p.last)
                    report_mismatch($sformatf(
                        {"product mismatch: exp row %0d col %0d dot %0d last %0b, ",
                         "got row %0d col %0d dot %0d last %0b"},
                        exp_p.row, exp_p.col, exp_p.dot, exp_p.last,
                        m_out_row, m_out_col, m_dot, m_last));
            end
        end
    end

    initial begin
        logic [DIM_W-1:0] dm;
        logic [DIM_W-1:0] dn;
        logic [DIM_W-1:0] dp;
        foreach (a_elems[i]) begin
            a_elems[i] = '0;
            b_elems[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset dimensions
        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].dot);

        // Random phases, each under its own dimension setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin dm = 4'd0;  dn = 4'd0;  dp = 4'd0;  end
                1: begin dm = 4'd1;  dn = 4'd8;  dp = 4'd1;  end
                2: begin dm = 4'd8;  dn = 4'd1;  dp = 4'd8;  end
                3: begin dm = 4'd15; dn = 4'd15; dp = 4'd15; end
                4: begin dm = 4'd9;  dn = 4'd3;  dp = 4'd0;  end
                default: begin
                    dm = DIM_W'($urandom_range(0, 15));
                    dn = DIM_W'($urandom_range(0, 15));
                    dp = DIM_W'($urandom_range(0, 15));
                end
            endcase
            no_gaps = (ph == 2);
            write_dims(dm, dn, dp);
            run_random(RANDOM_REQS / NUM_PHASES);
        end
        no_gaps = 1'b0;

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && product_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
